// ----- hdl/quote_aware_token_splitter_defines.svh -----
// Assertion macros used by the checker file.
`ifndef QUOTE_AWARE_TOKEN_SPLITTER_DEFINES_SVH
`define QUOTE_AWARE_TOKEN_SPLITTER_DEFINES_SVH

// Check in the same cycle.
`define QATS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qats check failed");

// Check in the next cycle.
`define QATS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qats check failed");

`endif

// ----- hdl/qats_pkg.sv -----
`default_nettype none
package qats_pkg;

	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int RUN_MAX = 3;
	localparam int RIW     = 2;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	typedef struct packed {
		logic [7:0] tb;
		logic       te;
	} res_t;

	typedef struct packed {
		logic [RIW-1:0]            count;
		res_t [RUN_MAX-1:0]        res;
	} run_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic is_sep(input logic [7:0] c);
		return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/quote_aware_token_splitter.sv -----
// Quote-aware token splitter.
// Input channel: in_valid / in_stall with in_byte and end_of_text, one text
// byte per beat; end_of_text marks the final byte of a text.
// Output channel: out_valid / out_stall with token_byte, token_end and
// last_of_run. Each input byte gives zero to three output beats; token_end
// beats carry token_byte 0, and last_of_run flags the final beat of a byte.
// A byte's beats are registered in the queue and offered from its head once
// earlier beats drain. Throughput: one byte per cycle while each byte gives
// at most one beat and out_stall is low; a byte giving more beats holds the
// output side until all are taken. The front end classifies a byte in its
// accepting cycle and writes its beats into a four-entry queue, so input is
// taken while earlier beats wait to drain. in_stall rises only when that
// queue is full. A stalled receiver sees the offered beat hold until taken.
// Reset clears the quote, token and backslash state and empties the queue;
// end_of_text also returns that state to reset after its byte.
`default_nettype none
module quote_aware_token_splitter import qats_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      token_byte,
	output logic            token_end,
	output logic            last_of_run
);

	logic   push, pop;
	run_t   push_run, head;
	qstat_t qstat;

	qats_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.push        (push),
		.push_run    (push_run),
		.qstat       (qstat)
	);

	qats_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	qats_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_byte  (token_byte),
		.token_end   (token_end),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

// ----- hdl/qats_front.sv -----
`default_nettype none
module qats_front import qats_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output logic            push,
	output run_t            push_run,
	input  wire qstat_t     qstat
);

	logic           iq_q, thb_q, bp_q;
	logic           iq_d, thb_d, bp_d;
	logic           handled;
	logic [RIW-1:0] n;
	run_t           run;
	logic           take;

	assign in_stall = qstat.full;
	assign take     = in_valid && !qstat.full;
	assign push     = take && (run.count != '0);
	assign push_run = run;

	always_comb begin
		run     = '0;
		n       = '0;
		handled = 1'b0;
		iq_d    = iq_q;
		thb_d   = thb_q;
		bp_d    = bp_q;
		if (bp_q) begin
			bp_d = 1'b0;
			thb_d = 1'b1;
			if (in_byte == CH_QUOTE) begin
				run.res[n] = '{tb: CH_QUOTE, te: 1'b0};
				handled = 1'b1;
			end else begin
				run.res[n] = '{tb: CH_BACKSLASH, te: 1'b0};
			end
			n = n + RIW'(1);
		end
		if (!handled) begin
			if (in_byte == CH_QUOTE) begin
				iq_d = !iq_q;
			end else if (in_byte == CH_BACKSLASH) begin
				if (end_of_text) begin
					run.res[n] = '{tb: CH_BACKSLASH, te: 1'b0};
					n = n + RIW'(1);
					thb_d = 1'b1;
				end else begin
					bp_d = 1'b1;
				end
			end else if (is_sep(in_byte) && !iq_q) begin
				if (thb_d) begin
					run.res[n] = '{tb: 8'h00, te: 1'b1};
					n = n + RIW'(1);
					thb_d = 1'b0;
				end
			end else begin
				run.res[n] = '{tb: in_byte, te: 1'b0};
				n = n + RIW'(1);
				thb_d = 1'b1;
			end
		end
		if (end_of_text) begin
			if (thb_d) begin
				run.res[n] = '{tb: 8'h00, te: 1'b1};
				n = n + RIW'(1);
			end
			iq_d  = 1'b0;
			thb_d = 1'b0;
			bp_d  = 1'b0;
		end
		run.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iq_q  <= 1'b0;
			thb_q <= 1'b0;
			bp_q  <= 1'b0;
		end else if (take) begin
			iq_q  <= iq_d;
			thb_q <= thb_d;
			bp_q  <= bp_d;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/qats_queue.sv -----
`default_nettype none
module qats_queue import qats_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire run_t push_run,
	input  wire logic pop,
	output run_t      head,
	output qstat_t    qstat
);

	run_t           mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0]   cnt_q;

	assign qstat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + (QAW+1)'(1);
				end
				2'b01: begin
					cnt_q <= cnt_q - (QAW+1)'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/qats_back.sv -----
`default_nettype none
module qats_back import qats_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire run_t       head,
	input  wire qstat_t     qstat,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      token_byte,
	output logic            token_end,
	output logic            last_of_run
);

	logic [RIW-1:0] idx_q;
	logic           beat;

	assign out_valid   = !qstat.empty;
	assign token_byte  = head.res[idx_q].tb;
	assign token_end   = head.res[idx_q].te;
	assign last_of_run = (idx_q == (head.count - RIW'(1)));
	assign beat        = out_valid && !out_stall;
	assign pop         = beat && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (beat) begin
			idx_q <= last_of_run ? '0 : idx_q + RIW'(1);
		end
	end

endmodule
`default_nettype wire

// ----- hdl/qats_checker.sv -----
`default_nettype none
`include "quote_aware_token_splitter_defines.svh"
module qats_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] token_byte,
	input wire logic       token_end,
	input wire logic       last_of_run
);

	logic prev_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_end_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			prev_end_q <= token_end;
		end
	end

	`QATS_ASSERT_NOW(a_end_zero, out_valid && token_end, token_byte == 8'h00)
	`QATS_ASSERT_NOW(a_end_closes_run, out_valid && token_end, last_of_run)
	`QATS_ASSERT_NOW(a_no_double_end, out_valid && token_end, !prev_end_q)
	`QATS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(token_byte) && $stable(token_end) && $stable(last_of_run))

endmodule

bind quote_aware_token_splitter qats_checker u_chk (.*);
`default_nettype wire

// ----- sim/quote_aware_token_splitter_tb.sv -----
`timescale 1ns / 1ps

module quote_aware_token_splitter_tb;
	import qats_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int RANDOM_ITEMS   = 150;

	typedef struct {
		logic [7:0] text_byte;
		logic       eot;
	} text_item_t;

	typedef struct {
		logic [7:0] tb;
		logic       te;
		logic       lr;
	} token_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] token_byte;
	logic       token_end;
	logic       last_of_run;

	text_item_t  text_bytes_pending[$];
	token_beat_t token_beats_due[$];

	logic quote_mode = 1'b0;
	logic token_open = 1'b0;
	logic backslash_held = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int bytes_taken = 0;
	int beats_seen = 0;
	int token_ends_seen = 0;
	int texts_queued = 0;
	int quiet_cycles = 0;

	quote_aware_token_splitter uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_byte  (token_byte),
		.token_end   (token_end),
		.last_of_run (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic split_text_byte(input logic [7:0] c, input logic eot);
		token_beat_t run[$];
		logic handled;
		handled = 1'b0;
		if (backslash_held) begin
			backslash_held = 1'b0;
			token_open = 1'b1;
			if (c == CH_QUOTE) begin
				run = {run, token_beat_t'{tb: CH_QUOTE, te: 1'b0, lr: 1'b0}};
				handled = 1'b1;
			end else begin
				run = {run, token_beat_t'{tb: CH_BACKSLASH, te: 1'b0, lr: 1'b0}};
			end
		end
		if (!handled) begin
			if (c == CH_QUOTE) begin
				quote_mode = !quote_mode;
			end else if (c == CH_BACKSLASH) begin
				if (eot) begin
					run = {run, token_beat_t'{tb: CH_BACKSLASH, te: 1'b0, lr: 1'b0}};
					token_open = 1'b1;
				end else begin
					backslash_held = 1'b1;
				end
			end else if (((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) && !quote_mode) begin
				if (token_open) begin
					run = {run, token_beat_t'{tb: 8'h00, te: 1'b1, lr: 1'b0}};
					token_open = 1'b0;
				end
			end else begin
				run = {run, token_beat_t'{tb: c, te: 1'b0, lr: 1'b0}};
				token_open = 1'b1;
			end
		end
		if (eot) begin
			if (token_open)
				run = {run, token_beat_t'{tb: 8'h00, te: 1'b1, lr: 1'b0}};
			quote_mode = 1'b0;
			token_open = 1'b0;
			backslash_held = 1'b0;
		end
		if (run.size() > 0)
			run[run.size() - 1].lr = 1'b1;
		foreach (run[i])
			token_beats_due = {token_beats_due, run[i]};
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			end_of_text <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				split_text_byte(in_byte, end_of_text);
				void'(text_bytes_pending.pop_front());
				bytes_taken++;
			end
			if (text_bytes_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_byte <= text_bytes_pending[0].text_byte;
				end_of_text <= text_bytes_pending[0].eot;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		token_beat_t due;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				beats_seen++;
				if (token_beats_due.size() == 0) begin
					$error("unexpected beat: token_byte %0h token_end %0b last_of_run %0b",
						token_byte, token_end, last_of_run);
					errors++;
				end else begin
					due = token_beats_due.pop_front();
					if (due.te)
						token_ends_seen++;
					if (token_byte !== due.tb) begin
						$error("token_byte: expected %0h, got %0h", due.tb, token_byte);
						errors++;
					end
					if (token_end !== due.te) begin
						$error("token_end: expected %0b, got %0b", due.te, token_end);
						errors++;
					end
					if (last_of_run !== due.lr) begin
						$error("last_of_run: expected %0b, got %0b", due.lr, last_of_run);
						errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: %0d bytes waiting, %0d beats due",
					text_bytes_pending.size(), token_beats_due.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic eot);
		text_bytes_pending = {text_bytes_pending, text_item_t'{text_byte: b, eot: eot}};
		if (eot)
			texts_queued++;
	endtask

	function automatic logic [7:0] pick_text_char();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return 8'(97 + $urandom_range(25));
		if (r < 55)
			return 8'($urandom_range(255));
		if (r < 72) begin
			if ($urandom_range(5) == 0)
				return CH_SPACE;
			return 8'($urandom_range(13, 9));
		end
		if (r < 86)
			return CH_QUOTE;
		return CH_BACKSLASH;
	endfunction

	task automatic queue_random_texts(input int n_items);
		int n;
		int len;
		n = 0;
		while (n < n_items) begin
			if ($urandom_range(9) == 0) begin
				queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
				n++;
			end else begin
				len = $urandom_range(12, 1);
				for (int i = 0; i < len; i++)
					queue_byte(pick_text_char(), i == len - 1);
				n += len;
			end
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		queue_random_texts(n_items);
		wait (text_bytes_pending.size() == 0 && !in_valid && token_beats_due.size() == 0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(CH_TAB, 1'b0);
		queue_byte(CH_CR, 1'b0);
		queue_byte(CH_SPACE, 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(CH_SPACE, 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(8'h0A, 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(8'h0B, 1'b0);
		queue_byte(CH_BACKSLASH, 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(CH_BACKSLASH, 1'b0);
		queue_byte(8'h71, 1'b0);
		queue_byte(CH_BACKSLASH, 1'b0);
		queue_byte(CH_BACKSLASH, 1'b1);
		queue_byte(CH_BACKSLASH, 1'b1);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(8'h80, 1'b1);
		queue_byte(8'h08, 1'b0);
		queue_byte(8'h0E, 1'b1);
		wait (text_bytes_pending.size() == 0 && !in_valid && token_beats_due.size() == 0);

		run_phase(0, 0, RANDOM_ITEMS / 4);
		run_phase(88, 0, RANDOM_ITEMS / 4);
		run_phase(0, 88, RANDOM_ITEMS / 4);
		run_phase(13, 13, RANDOM_ITEMS / 4);
		send_idle_pct = 0;
		recv_stall_pct = 0;

		repeat (SETTLE_CYCLES) @(posedge clk);
		errors += token_beats_due.size();

		$display("covered %0d bytes in %0d texts, %0d beats with %0d token ends,",
			bytes_taken, texts_queued, beats_seen, token_ends_seen);
		$display("with free-running, sender-idle, receiver-stall and mixed throttling");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
